// ----- src/cbal_pkg.sv -----
// ----------------------------------------------------------------------------
// cbal_pkg: shared types and constants
// Fixed-point widths, the operation schedule and the sequencer states of the
// cubic Bezier arc length block.
// ----------------------------------------------------------------------------
package cbal_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned T_W     = 31;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned RAD_W   = 66;
  localparam int unsigned ROOT_W  = 33;
  localparam int unsigned LEN_W   = 48;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned OP_W    = 4;

  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(20);
  localparam logic [T_W-1:0]   T_ONE     = T_W'(1) << 30;

  // Operation numbers: six first-level lerps, four second-level, two final,
  // then the two squares of the chord.
  localparam logic [OP_W-1:0] OP_AX  = 4'd0;
  localparam logic [OP_W-1:0] OP_AY  = 4'd1;
  localparam logic [OP_W-1:0] OP_BX  = 4'd2;
  localparam logic [OP_W-1:0] OP_BY  = 4'd3;
  localparam logic [OP_W-1:0] OP_CX  = 4'd4;
  localparam logic [OP_W-1:0] OP_CY  = 4'd5;
  localparam logic [OP_W-1:0] OP_DX  = 4'd6;
  localparam logic [OP_W-1:0] OP_DY  = 4'd7;
  localparam logic [OP_W-1:0] OP_EX  = 4'd8;
  localparam logic [OP_W-1:0] OP_EY  = 4'd9;
  localparam logic [OP_W-1:0] OP_FX  = 4'd10;
  localparam logic [OP_W-1:0] OP_FY  = 4'd11;
  localparam logic [OP_W-1:0] OP_SQX = 4'd12;
  localparam logic [OP_W-1:0] OP_SQY = 4'd13;
  localparam logic [OP_W-1:0] OP_END = 4'd14;

  typedef enum logic {
    MODE_LERP,
    MODE_SQUARE
  } mul_mode_t;

  typedef struct packed {
    logic             vld;
    mul_mode_t        mode;
    logic [OP_W-1:0]  tag;
  } mul_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_EVAL,
    ST_ROOT_GO,
    ST_ROOT,
    ST_ACC,
    ST_DONE
  } seq_state_t;

endpackage

// ----- src/cbal_mul.sv -----
// ----------------------------------------------------------------------------
// cbal_mul: shared multiply unit
// Registers (a - b) * t or (a - b)^2, then finishes the rounded lerp.
// ----------------------------------------------------------------------------
module cbal_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  cbal_pkg::mul_ctl_t                  ctl,
  input  logic signed [cbal_pkg::COORD_W-1:0] a,
  input  logic signed [cbal_pkg::COORD_W-1:0] b,
  input  logic        [cbal_pkg::T_W-1:0]     t,
  output cbal_pkg::mul_ctl_t                  res_ctl,
  output logic signed [cbal_pkg::COORD_W-1:0] lerp_res,
  output logic        [cbal_pkg::SQ_W-1:0]    sq_res
);

  logic signed [cbal_pkg::DIFF_W-1:0] diff;
  logic signed [cbal_pkg::DIFF_W-1:0] mult_b;
  logic signed [cbal_pkg::PROD_W-1:0] prod;
  logic signed [cbal_pkg::COORD_W-1:0] a_hold;
  logic signed [cbal_pkg::PROD_W-1:0] rounded;

  assign diff   = cbal_pkg::DIFF_W'(a) - cbal_pkg::DIFF_W'(b);
  assign mult_b = (ctl.mode == cbal_pkg::MODE_SQUARE) ? diff
                : $signed({2'b00, t});

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ctl <= '0;
    end else begin
      res_ctl <= ctl;
    end
    prod   <= diff * mult_b;
    a_hold <= a;
  end

  // floor((p + 2^29) / 2^30), then subtract from a; the result stays in range
  assign rounded  = (prod + cbal_pkg::PROD_W'(64'sd536870912)) >>> 30;
  assign lerp_res = a_hold - rounded[cbal_pkg::COORD_W-1:0];
  assign sq_res   = prod[cbal_pkg::SQ_W-1:0];

endmodule

// ----- src/cbal_recip.sv -----
// ----------------------------------------------------------------------------
// cbal_recip: serial reciprocal
// Restoring division of 2^30 by the segment count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cbal_recip (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cbal_pkg::SEG_W-1:0]    divisor,
  output logic                          done,
  output logic [cbal_pkg::T_W-1:0]      quot
);

  logic                          busy;
  logic [4:0]                    cnt;
  logic [cbal_pkg::SEG_W-1:0]    rem;
  logic [cbal_pkg::SEG_W:0]      rem_sh;
  logic                          fits;

  assign rem_sh = {rem, (cnt == 5'd30)};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      cnt  <= 5'd30;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      cnt  <= cnt - 5'd1;
      rem  <= fits ? cbal_pkg::SEG_W'(rem_sh - {1'b0, divisor})
                   : rem_sh[cbal_pkg::SEG_W-1:0];
      quot <= {quot[cbal_pkg::T_W-2:0], fits};
    end
  end

endmodule

// ----- src/cbal_isqrt.sv -----
// ----------------------------------------------------------------------------
// cbal_isqrt: serial integer square root
// Digit-by-digit floor square root of a 66-bit radicand, one bit a cycle.
// ----------------------------------------------------------------------------
module cbal_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cbal_pkg::RAD_W-1:0]     radicand,
  output logic                           done,
  output logic [cbal_pkg::ROOT_W-1:0]    root
);

  logic                          busy;
  logic [5:0]                    cnt;
  logic [cbal_pkg::RAD_W-1:0]    rad;
  logic [35:0]                   rem;
  logic [35:0]                   rem_sh;
  logic [35:0]                   trial;
  logic                          fits;

  // Trial value is 4 * root + 1 for the next root bit
  assign rem_sh = {rem[33:0], rad[cbal_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      cnt  <= 6'd32;
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      cnt  <= cnt - 6'd1;
      rad  <= {rad[cbal_pkg::RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[cbal_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

// ----- src/cubic_bezier_arc_length.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_arc_length: chord-sum length of a cubic Bezier curve
// Evaluates the curve at N equal parameter steps by de Casteljau and sums
// the chord lengths in unsigned Q32.16 with saturation.
// ----------------------------------------------------------------------------
// One curve is in flight at a time; the serial reciprocal, the serial square
//   root (one per chord) and the shared multiplier, which issues 14 operations
//   per segment, set how long each curve takes.
// Reset: synchronous, active high; returns to idle, drops any result held,
//   and sets segment_count to 20.
module cubic_bezier_arc_length (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cbal_pkg::SEG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cbal_pkg::COORD_W-1:0]  start_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  start_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  ctrl1_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  ctrl1_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  ctrl2_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  ctrl2_y,
  input  logic signed [cbal_pkg::COORD_W-1:0]  end_x,
  input  logic signed [cbal_pkg::COORD_W-1:0]  end_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cbal_pkg::LEN_W-1:0]           arc_length,
  output logic                                 length_saturated
);

  cbal_pkg::seq_state_t state, state_next;

  logic [cbal_pkg::SEG_W-1:0] segment_count;
  logic [cbal_pkg::SEG_W-1:0] n_seg;
  logic [cbal_pkg::SEG_W-1:0] seg_idx;
  logic [cbal_pkg::T_W-1:0]   recip;
  logic [cbal_pkg::T_W-1:0]   t_cur;
  logic [cbal_pkg::OP_W-1:0]  op;

  // Control points and intermediate points of the de Casteljau tree
  logic signed [cbal_pkg::COORD_W-1:0] p0_x, p0_y, p1_x, p1_y;
  logic signed [cbal_pkg::COORD_W-1:0] p2_x, p2_y, p3_x, p3_y;
  logic signed [cbal_pkg::COORD_W-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic signed [cbal_pkg::COORD_W-1:0] d_x, d_y, e_x, e_y;
  logic signed [cbal_pkg::COORD_W-1:0] cur_x, cur_y, prev_x, prev_y;
  logic [cbal_pkg::SQ_W-1:0]           sq_x, sq_y;

  logic [cbal_pkg::LEN_W-1:0] sum;
  logic                       sat;
  logic [cbal_pkg::LEN_W:0]   sum_next;

  logic                       in_fire;
  logic                       last_seg;
  logic                       div_start, div_done;
  logic [cbal_pkg::T_W-1:0]   div_quot;
  logic                       root_start, root_done;
  logic [cbal_pkg::ROOT_W-1:0] root;
  logic [cbal_pkg::RAD_W-1:0] radicand;

  cbal_pkg::mul_ctl_t                  issue, wb;
  logic signed [cbal_pkg::COORD_W-1:0] op_a, op_b;
  logic signed [cbal_pkg::COORD_W-1:0] lerp_res;
  logic [cbal_pkg::SQ_W-1:0]           sq_res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign last_seg  = (seg_idx == n_seg);
  assign sum_next  = {1'b0, sum} + (cbal_pkg::LEN_W + 1)'(root);
  assign radicand  = {1'b0, {1'b0, sq_x} + {1'b0, sq_y}};

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= cbal_pkg::SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      segment_count <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cbal_pkg::ST_IDLE:    if (in_fire) state_next = cbal_pkg::ST_RECIP;
      cbal_pkg::ST_RECIP:   if (div_done) state_next = cbal_pkg::ST_EVAL;
      cbal_pkg::ST_EVAL:    if (op == cbal_pkg::OP_END) state_next = cbal_pkg::ST_ROOT_GO;
      cbal_pkg::ST_ROOT_GO: state_next = cbal_pkg::ST_ROOT;
      cbal_pkg::ST_ROOT:    if (root_done) state_next = cbal_pkg::ST_ACC;
      cbal_pkg::ST_ACC:     state_next = last_seg ? cbal_pkg::ST_DONE : cbal_pkg::ST_EVAL;
      cbal_pkg::ST_DONE:    if (!out_valid || out_ready) state_next = cbal_pkg::ST_IDLE;
      default:              state_next = cbal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    root_start = 1'b0;
    issue      = '0;
    case (state)
      cbal_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid;
      end
      cbal_pkg::ST_EVAL: begin
        issue.vld  = (op != cbal_pkg::OP_END);
        issue.mode = (op == cbal_pkg::OP_SQX || op == cbal_pkg::OP_SQY)
                   ? cbal_pkg::MODE_SQUARE : cbal_pkg::MODE_LERP;
        issue.tag  = op;
      end
      cbal_pkg::ST_ROOT_GO: root_start = 1'b1;
      default: ;
    endcase
  end

  // Operand select for the issued operation; each lerp is (a, b) at t
  always_comb begin
    case (op)
      cbal_pkg::OP_AX:  begin op_a = p0_x;   op_b = p1_x; end
      cbal_pkg::OP_AY:  begin op_a = p0_y;   op_b = p1_y; end
      cbal_pkg::OP_BX:  begin op_a = p1_x;   op_b = p2_x; end
      cbal_pkg::OP_BY:  begin op_a = p1_y;   op_b = p2_y; end
      cbal_pkg::OP_CX:  begin op_a = p2_x;   op_b = p3_x; end
      cbal_pkg::OP_CY:  begin op_a = p2_y;   op_b = p3_y; end
      cbal_pkg::OP_DX:  begin op_a = a_x;    op_b = b_x;  end
      cbal_pkg::OP_DY:  begin op_a = a_y;    op_b = b_y;  end
      cbal_pkg::OP_EX:  begin op_a = b_x;    op_b = c_x;  end
      cbal_pkg::OP_EY:  begin op_a = b_y;    op_b = c_y;  end
      cbal_pkg::OP_FX:  begin op_a = d_x;    op_b = e_x;  end
      cbal_pkg::OP_FY:  begin op_a = d_y;    op_b = e_y;  end
      cbal_pkg::OP_SQX: begin op_a = cur_x;  op_b = prev_x; end
      cbal_pkg::OP_SQY: begin op_a = cur_y;  op_b = prev_y; end
      default:          begin op_a = '0;     op_b = '0;   end
    endcase
  end

  cbal_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .ctl      (issue),
    .a        (op_a),
    .b        (op_b),
    .t        (t_cur),
    .res_ctl  (wb),
    .lerp_res (lerp_res),
    .sq_res   (sq_res)
  );

  cbal_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (n_seg),
    .done    (div_done),
    .quot    (div_quot)
  );

  cbal_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  // Datapath: capture the curve, advance t, write back results, accumulate
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p0_x   <= start_x;  p0_y <= start_y;
      p1_x   <= ctrl1_x;  p1_y <= ctrl1_y;
      p2_x   <= ctrl2_x;  p2_y <= ctrl2_y;
      p3_x   <= end_x;    p3_y <= end_y;
      prev_x <= start_x;  prev_y <= start_y;
      n_seg  <= (segment_count == '0) ? cbal_pkg::SEG_W'(1) : segment_count;
      sum    <= '0;
      sat    <= 1'b0;
    end
    if (state == cbal_pkg::ST_RECIP && div_done) begin
      recip   <= div_quot;
      seg_idx <= cbal_pkg::SEG_W'(1);
      t_cur   <= (n_seg == cbal_pkg::SEG_W'(1)) ? cbal_pkg::T_ONE : div_quot;
    end
    if (state == cbal_pkg::ST_EVAL) begin
      op <= op + cbal_pkg::OP_W'(1);
    end else begin
      op <= cbal_pkg::OP_AX;
    end
    if (wb.vld) begin
      case (wb.tag)
        cbal_pkg::OP_AX:  a_x   <= lerp_res;
        cbal_pkg::OP_AY:  a_y   <= lerp_res;
        cbal_pkg::OP_BX:  b_x   <= lerp_res;
        cbal_pkg::OP_BY:  b_y   <= lerp_res;
        cbal_pkg::OP_CX:  c_x   <= lerp_res;
        cbal_pkg::OP_CY:  c_y   <= lerp_res;
        cbal_pkg::OP_DX:  d_x   <= lerp_res;
        cbal_pkg::OP_DY:  d_y   <= lerp_res;
        cbal_pkg::OP_EX:  e_x   <= lerp_res;
        cbal_pkg::OP_EY:  e_y   <= lerp_res;
        cbal_pkg::OP_FX:  cur_x <= lerp_res;
        cbal_pkg::OP_FY:  cur_y <= lerp_res;
        cbal_pkg::OP_SQX: sq_x  <= sq_res;
        cbal_pkg::OP_SQY: sq_y  <= sq_res;
        default: ;
      endcase
    end
    if (state == cbal_pkg::ST_ACC) begin
      // Hold the flag once the sum has passed 2^48 - 1
      sum     <= sum_next[cbal_pkg::LEN_W-1:0];
      sat     <= sat | sum_next[cbal_pkg::LEN_W];
      prev_x  <= cur_x;
      prev_y  <= cur_y;
      seg_idx <= seg_idx + cbal_pkg::SEG_W'(1);
      t_cur   <= (seg_idx + cbal_pkg::SEG_W'(1) == n_seg) ? cbal_pkg::T_ONE
                                                         : t_cur + recip;
    end
  end

  // Output register: lets the next curve in while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cbal_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == cbal_pkg::ST_DONE && (!out_valid || out_ready)) begin
      arc_length       <= sat ? '1 : sum;
      length_saturated <= sat;
    end
  end

endmodule

// ----- src/cbal_checker.sv -----
// ----------------------------------------------------------------------------
// cbal_props: port-level checks
// Watches the top-level ports of the arc length block over time.
// ----------------------------------------------------------------------------
module cbal_props (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [cbal_pkg::LEN_W-1:0]          arc_length,
  input logic                                length_saturated
);

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(arc_length))
    else $error("result changed while stalled");

  // Saturated results read as all ones
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_saturated |-> arc_length == '1)
    else $error("saturated length not at maximum");

  // The block is busy after taking a curve
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction");

  // Reset drops any pending result
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cubic_bezier_arc_length cbal_props u_cbal_props (.*);
